// ===== src/sfd_pkg.sv =====
package sfd_pkg;

    localparam int C_DELAY_DEPTH      = 4096;
    localparam int C_SAMPLE_RATE      = 48000;
    localparam int C_SINE_TABLE_DEPTH = 1024;

    localparam int SAMP_W    = 24;
    localparam int RATE_W    = 7;
    localparam int Q8_W      = 18;
    localparam int CFG_IDX_W = 2;
    localparam int RATE_MAX  = 100;
    localparam int SINE_W    = 16;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE     = 2'd0,
        CFG_DEPTH    = 2'd1,
        CFG_PREDELAY = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMP_W-1:0] left;
        logic signed [SAMP_W-1:0] right;
    } t_frame;

    // Q15 sine of a 32-bit phase (full scale one cycle), degree-9 polynomial in Q30.
    function automatic logic signed [SINE_W-1:0] sine_q15(input logic [63:0] p);
        logic [1:0]  quad;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        quad = p[31:30];
        x    = {34'd0, p[29:0]};
        if (quad[0]) begin
            x = Q30_ONE - x;
        end
        r  = (x * HALF_PI_Q30) >> 30;
        x2 = (r * r) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (r * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return quad[1] ? -SINE_W'(s) : SINE_W'(s);
    endfunction

endpackage

// ===== src/sfd_ram.sv =====
module sfd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sfd_front.sv =====
module sfd_front
    import sfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_frame i_frame,
    output logic   o_q_valid,
    input  logic   i_q_ready,
    output t_frame o_q_frame
);

    // two-entry queue, head in slot 0
    t_frame     r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_frame  = r_q[0];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push) begin
            if (pop) begin
                if (r_cnt == 2'd1) begin
                    r_q[0] <= i_frame;
                end else begin
                    r_q[1] <= i_frame;
                end
            end else if (r_cnt == 2'd0) begin
                r_q[0] <= i_frame;
            end else begin
                r_q[1] <= i_frame;
            end
        end
    end

endmodule

// ===== src/sfd_back.sv =====
module sfd_back
    import sfd_pkg::*;
#(
    parameter int DELAY_DEPTH      = C_DELAY_DEPTH,
    parameter int SAMPLE_RATE      = C_SAMPLE_RATE,
    parameter int SINE_TABLE_DEPTH = C_SINE_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_ready,
    input  t_frame                   i_q_frame,
    input  logic [RATE_W-1:0]        i_rate,
    input  logic [Q8_W-1:0]          i_depth,
    input  logic [Q8_W-1:0]          i_predelay,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SAMP_W-1:0] o_left_out,
    output logic signed [SAMP_W-1:0] o_right_out
);

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int FW   = $clog2(DELAY_DEPTH + 1);
    localparam int SW   = $clog2(SINE_TABLE_DEPTH);
    localparam int PW   = (AW + 9 > 21) ? AW + 9 : 21;
    localparam int LFOW = 19;
    localparam logic [PW-1:0] LIMIT = PW'(DELAY_DEPTH - 2) << 8;
    localparam logic [PW-1:0] RING8 = PW'(DELAY_DEPTH) << 8;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SINE = 9'b000000010,
        ST_MUL  = 9'b000000100,
        ST_SUM  = 9'b000001000,
        ST_ADR  = 9'b000010000,
        ST_RDA  = 9'b000100000,
        ST_RDB  = 9'b001000000,
        ST_FETB = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // sine ROM and phase increment table, built at elaboration
    logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
    logic [31:0]              inc_tab  [RATE_MAX+1];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] P = (64'(k) << 32) / SINE_TABLE_DEPTH;
        assign sine_rom[k] = sine_q15(P);
    end

    for (genvar k = 0; k <= RATE_MAX; k++) begin : g_inc
        localparam logic [63:0] INC =
            ((64'(100 + 49 * k) << 32) + 64'(500) * SAMPLE_RATE) / (64'(1000) * SAMPLE_RATE);
        assign inc_tab[k] = INC[31:0];
    end

    logic [31:0]              r_phase;
    logic [AW-1:0]            r_wp;
    logic [FW-1:0]            r_fill;
    t_frame                   r_frame;
    logic [SW-1:0]            r_sidx;
    logic signed [SINE_W-1:0] r_sine;
    logic [LFOW-1:0]          r_lfo;
    logic [PW-1:0]            r_total;
    logic [AW-1:0]            r_whole;
    logic [AW-1:0]            r_next;
    logic [7:0]               r_frac;
    logic [2*SAMP_W-1:0]      r_a;
    logic [2*SAMP_W-1:0]      r_b;
    logic                     r_out_valid;
    logic signed [SAMP_W-1:0] r_left_out;
    logic signed [SAMP_W-1:0] r_right_out;

    logic [63:0]         sidx_prod;
    logic [34:0]         lfo_prod;
    logic [PW-1:0]       total_sum;
    logic [PW-1:0]       wp8;
    logic [PW-1:0]       pos;
    logic [PW-1:0]       whole_w;
    logic [AW-1:0]       whole_n;
    logic [AW-1:0]       next_n;
    logic [AW-1:0]       ram_raddr;
    logic [2*SAMP_W-1:0] ram_rdata;
    logic                ram_we;
    logic                rd_ok;
    logic [6:0]          rate_c;
    logic                fire;
    logic [34:0]         mix_l;
    logic [34:0]         mix_r;
    logic [34:0]         wa;
    logic [34:0]         wb;

    assign sidx_prod = 64'(r_phase) * 64'(SINE_TABLE_DEPTH);
    // 65536 + sine as a 17-bit unsigned value: inverted sign bit over the Q15 word
    assign lfo_prod  = 35'(i_depth) * 35'({~r_sine[SINE_W-1], r_sine});
    assign total_sum = PW'(r_lfo) + PW'(i_predelay);
    assign wp8       = PW'(r_wp) << 8;

    always_comb begin
        if (r_total > wp8) begin
            pos = wp8 + RING8 - r_total;
        end else begin
            pos = wp8 - r_total;
        end
        whole_w = pos >> 8;
        if (whole_w >= PW'(DELAY_DEPTH)) begin
            whole_w = whole_w - PW'(DELAY_DEPTH);
        end
        whole_n = whole_w[AW-1:0];
        if (whole_w + PW'(1) >= PW'(DELAY_DEPTH)) begin
            next_n = '0;
        end else begin
            next_n = whole_n + AW'(1);
        end
    end

    assign ram_raddr = (r_state == ST_RDA) ? r_whole : r_next;
    // entries not yet written since reset read as zero
    assign rd_ok     = (r_state == ST_RDB) ? (FW'(r_whole) < r_fill) : (FW'(r_next) < r_fill);
    assign rate_c    = (i_rate > RATE_W'(RATE_MAX)) ? 7'(RATE_MAX) : i_rate;
    assign fire      = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign ram_we    = fire;
    assign o_q_ready = (r_state == ST_IDLE);

    // a*(256-f) + b*f + 128, floored by 8
    assign wa    = 35'(9'd256 - 9'(r_frac));
    assign wb    = 35'(r_frac);
    assign mix_l = 35'($signed(r_a[2*SAMP_W-1:SAMP_W])) * wa
                 + 35'($signed(r_b[2*SAMP_W-1:SAMP_W])) * wb + 35'd128;
    assign mix_r = 35'($signed(r_a[SAMP_W-1:0])) * wa
                 + 35'($signed(r_b[SAMP_W-1:0])) * wb + 35'd128;

    sfd_ram #(
        .WIDTH(2 * SAMP_W),
        .DEPTH(DELAY_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wp),
        .i_wdata(r_frame),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_SINE;
            ST_SINE: n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_ADR;
            ST_ADR:  n_state = ST_RDA;
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_FETB;
            ST_FETB: n_state = ST_OUT;
            ST_OUT:  if (fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
                r_phase     <= r_phase + inc_tab[rate_c];
                r_wp        <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != FW'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_frame <= i_q_frame;
                r_sidx  <= sidx_prod[32 +: SW];
            end
            ST_SINE: r_sine  <= sine_rom[r_sidx];
            ST_MUL:  r_lfo   <= lfo_prod[34:16];
            ST_SUM:  r_total <= (total_sum > LIMIT) ? LIMIT : total_sum;
            ST_ADR: begin
                r_whole <= whole_n;
                r_next  <= next_n;
                r_frac  <= pos[7:0];
            end
            ST_RDB:  r_a <= rd_ok ? ram_rdata : '0;
            ST_FETB: r_b <= rd_ok ? ram_rdata : '0;
            ST_OUT: begin
                if (fire) begin
                    r_left_out  <= mix_l[31:8];
                    r_right_out <= mix_r[31:8];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

// ===== src/stereo_flanger_delay.sv =====
// Stereo flanger delay line with a sine LFO.
// Input channel (i_in_valid/o_in_ready): one stereo frame of signed 24-bit
// samples per transfer. Output channel (o_out_valid/i_out_ready): one wet
// frame per input frame, in order, no dry mix.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 rate_percent,
// 1 depth_q8, 2 predelay_q8; index 3 is ignored. Write only while idle.
// A frame passes the input queue, the back-end states IDLE, SINE, MUL, SUM,
// ADR, RDA, RDB, FETB and OUT, then the output register. The back-end
// sequencer handles one frame at a time (sine ROM, depth multiply, two reads
// of the single-read-port ring RAM, interpolation and write-back).
// A two-frame input queue keeps o_in_ready high while the back end works or a
// result waits, until both slots are full; with the receiver stalled the back
// end holds its finished frame until the output register frees.
// Reset: phase, write pointer and registers clear; the ring RAM is not swept,
// a fill count makes entries never written since reset read as zero, so the
// block is ready in the first cycle after reset.
module stereo_flanger_delay
    import sfd_pkg::*;
#(
    parameter int DELAY_DEPTH      = C_DELAY_DEPTH,
    parameter int SAMPLE_RATE      = C_SAMPLE_RATE,
    parameter int SINE_TABLE_DEPTH = C_SINE_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [SAMP_W-1:0] i_left_in,
    input  logic signed [SAMP_W-1:0] i_right_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SAMP_W-1:0] o_left_out,
    output logic signed [SAMP_W-1:0] o_right_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [Q8_W-1:0]          i_cfg_data
);

    logic [RATE_W-1:0] r_rate;
    logic [Q8_W-1:0]   r_depth;
    logic [Q8_W-1:0]   r_predelay;

    t_frame in_frame;
    t_frame q_frame;
    logic   q_valid;
    logic   q_ready;

    assign o_cfg_ready = 1'b1;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= '0;
            r_depth    <= '0;
            r_predelay <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATE:     r_rate     <= i_cfg_data[RATE_W-1:0];
                CFG_DEPTH:    r_depth    <= i_cfg_data;
                CFG_PREDELAY: r_predelay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_frame.left  = i_left_in;
    assign in_frame.right = i_right_in;

    sfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_frame   (in_frame),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_frame (q_frame)
    );

    sfd_back #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_frame  (q_frame),
        .i_rate     (r_rate),
        .i_depth    (r_depth),
        .i_predelay (r_predelay),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_left_out (o_left_out),
        .o_right_out(o_right_out)
    );

endmodule

// ===== src/sfd_checker.sv =====
module sfd_checker
    import sfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [SAMP_W-1:0] o_left_out,
    input logic              o_cfg_ready
);

    // frames inside the block: queue (2) + back end (1) + output register (1)
    logic [2:0] r_inflight;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_xfer) - 3'(out_xfer);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_out))
        else $error("output dropped or changed while stalled");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more frames in flight than storage");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != 3'd0)
        else $error("output without a pending input frame");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && o_cfg_ready)
        else $error("not idle after reset");

endmodule

bind stereo_flanger_delay sfd_checker u_sfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_left_out (o_left_out),
    .o_cfg_ready(o_cfg_ready)
);

// ===== tb/sv/tb_stereo_flanger_delay.sv =====
`timescale 1ns / 1ps

module tb_stereo_flanger_delay;
    import sfd_pkg::*;

    localparam int RING_N   = C_DELAY_DEPTH;
    localparam int ROM_N    = C_SINE_TABLE_DEPTH;
    localparam int SETTLE   = 20;
    localparam int MAX_CYC  = 400000;

    // Flanger predictor plus in-order store of expected wet frames.
    class flanger_board;
        int                       sine_tab[ROM_N];
        logic signed [SAMP_W-1:0] ring_l[RING_N];
        logic signed [SAMP_W-1:0] ring_r[RING_N];
        int unsigned              wr_pos;
        logic [31:0]              phase;
        int unsigned              rate, depth, predelay;
        logic [SAMP_W-1:0]        exp_l[$];
        logic [SAMP_W-1:0]        exp_r[$];
        int                       errors;

        function new();
            longint unsigned p, x, r, x2, t, s;
            for (int k = 0; k < ROM_N; k++) begin
                p = (longint'(k) << 32) / ROM_N;
                x = p & 64'h3FFF_FFFF;
                if (p[30]) x = 64'd1073741824 - x;
                r  = (x * 64'd1686629713) >> 30;
                x2 = (r * r) >> 30;
                t  = 64'd1073741824 - x2 / 72;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
                t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
                s  = (r * t) >> 30;
                s  = (s + 16384) >> 15;
                if (s > 32767) s = 32767;
                sine_tab[k] = p[31] ? -int'(s) : int'(s);
            end
            foreach (ring_l[i]) begin
                ring_l[i] = '0;
                ring_r[i] = '0;
            end
            wr_pos = 0; phase = '0; rate = 0; depth = 0; predelay = 0; errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [Q8_W-1:0] data);
            case (idx)
                CFG_RATE:     rate     = data[RATE_W-1:0];
                CFG_DEPTH:    depth    = data;
                CFG_PREDELAY: predelay = data;
                default: ;
            endcase
        endfunction

        function logic [SAMP_W-1:0] blend(logic signed [SAMP_W-1:0] a,
                                          logic signed [SAMP_W-1:0] b, int f);
            longint acc;
            acc = longint'(a) * (256 - f) + longint'(b) * f + 128;
            return SAMP_W'(acc >>> 8);
        endfunction

        // Accepted input frame: predict its wet frame, then write the ring.
        function void note_frame(logic signed [SAMP_W-1:0] l, logic signed [SAMP_W-1:0] r);
            longint unsigned dly, pos, wp8, inc;
            int unsigned     whole, nxt, frac, rt;
            dly = (longint'(depth) * longint'(65536 + sine_tab[phase[31:22]])) >> 16;
            dly += predelay;
            if (dly > (longint'(RING_N - 2) << 8)) dly = longint'(RING_N - 2) << 8;
            wp8 = longint'(wr_pos) << 8;
            pos = (dly > wp8) ? wp8 + (longint'(RING_N) << 8) - dly : wp8 - dly;
            whole = pos >> 8;
            frac  = pos & 255;
            if (whole >= RING_N) whole -= RING_N;
            nxt = (whole + 1 >= RING_N) ? 0 : whole + 1;
            exp_l.push_back(blend(ring_l[whole], ring_l[nxt], frac));
            exp_r.push_back(blend(ring_r[whole], ring_r[nxt], frac));
            ring_l[wr_pos] = l;
            ring_r[wr_pos] = r;
            wr_pos = (wr_pos + 1) % RING_N;
            rt  = (rate > RATE_MAX) ? RATE_MAX : rate;
            inc = ((longint'(100 + 49 * rt) << 32) + 500 * longint'(C_SAMPLE_RATE))
                  / (1000 * longint'(C_SAMPLE_RATE));
            phase = phase + 32'(inc);
        endfunction

        function void check_frame(logic [SAMP_W-1:0] l, logic [SAMP_W-1:0] r);
            logic [SAMP_W-1:0] el, er;
            if (exp_l.size() == 0) begin
                $display("%0t: unexpected output frame L=%h R=%h", $time, l, r);
                errors++;
                return;
            end
            el = exp_l.pop_front();
            er = exp_r.pop_front();
            if (l !== el) begin
                $display("%0t: left_out expected %h actual %h", $time, el, l);
                errors++;
            end
            if (r !== er) begin
                $display("%0t: right_out expected %h actual %h", $time, er, r);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [SAMP_W-1:0] i_left_in = '0;
    logic signed [SAMP_W-1:0] i_right_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [SAMP_W-1:0] o_left_out;
    logic signed [SAMP_W-1:0] o_right_out;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [Q8_W-1:0]          i_cfg_data = '0;

    flanger_board sb = new();
    bit           calm;        // no idling on either side while set
    int           cycles;

    stereo_flanger_delay u_top (.*);

    always #2 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver side: check each output transfer, stall about 22% of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_frame(o_left_out, o_right_out);
        end
        i_out_ready <= calm || ($urandom_range(99) >= 22);
    end

    // One register write; valid drops afterwards, so back-to-back writes are safe.
    task automatic reg_write(t_cfg_idx idx, logic [Q8_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected frame is back plus the pipeline latency.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.exp_l.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(int unsigned rt, int unsigned dp, int unsigned pd);
        drain();
        reg_write(CFG_RATE, Q8_W'(rt));
        reg_write(CFG_DEPTH, Q8_W'(dp));
        reg_write(CFG_PREDELAY, Q8_W'(pd));
    endtask

    // One input transfer. Valid is only lowered when a gap is inserted.
    task automatic send_frame(logic signed [SAMP_W-1:0] l, logic signed [SAMP_W-1:0] r);
        if (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_frame(l, r);
    endtask

    function automatic logic signed [SAMP_W-1:0] rand_samp();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return '0;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned rand_q8();
        case ($urandom_range(5))
            0: return 0;
            1: return (1 << Q8_W) - 1;
            2: return $urandom_range(2047);
            default: return $urandom_range(20000);
        endcase
    endfunction

    initial begin
        cycles = 0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Half-sample delay at write position 0: second tap wraps to entry 0.
        reg_write(CFG_PREDELAY, Q8_W'(128));
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(24'sh800000, 24'sh7FFFFF);
        send_frame(24'sh000001, -24'sh1);

        // Zero delay reads the entry not yet overwritten.
        set_regs(0, 0, 0);
        send_frame(24'sh123456, -24'sh654321);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);

        // One-sample and fractional delays on extreme samples.
        set_regs(RATE_MAX, 0, 256);
        for (int i = 0; i < 6; i++) send_frame(i[0] ? 24'sh7FFFFF : 24'sh800000,
                                              i[0] ? 24'sh800000 : 24'sh7FFFFF);
        set_regs(RATE_MAX, 512, 77);
        for (int i = 0; i < 5; i++) send_frame(rand_samp(), rand_samp());

        // Rate register above range, depth and predelay at max: saturated delay.
        set_regs((1 << RATE_W) - 1, (1 << Q8_W) - 1, (1 << Q8_W) - 1);
        for (int i = 0; i < 4; i++) send_frame(rand_samp(), rand_samp());

        // Unknown register index must leave the settings alone.
        drain();
        reg_write(CFG_NONE, Q8_W'($urandom));
        for (int i = 0; i < 3; i++) send_frame(rand_samp(), rand_samp());

        // Random phases; rate changes mid-run keep the phase continuous.
        for (int ph = 0; ph < 9; ph++) begin
            set_regs($urandom_range(ph == 0 ? 0 : 127), rand_q8(), rand_q8());
            if ($urandom_range(3) == 0) reg_write(CFG_NONE, Q8_W'($urandom));
            calm = (ph == 4);
            for (int i = 0; i < 58; i++) send_frame(rand_samp(), rand_samp());
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
